@@ hw/rtl/pci_pkg.sv @@
// ----------------------------------------------------------------------------
// pci_pkg
// Shared widths, constants and word types of the particle contact impulse
// block.
// ----------------------------------------------------------------------------
package pci_pkg;

  // Default width to which result velocities saturate.
  localparam int PCI_VEL_WIDTH = 32;

  localparam int VEL_W  = 32;  // velocity field, signed Q16.16
  localparam int INV_W  = 32;  // inverse mass, unsigned Q16.16
  localparam int NRM_W  = 16;  // normal component, signed Q1.14
  localparam int REST_W = 17;  // restitution, unsigned Q1.16

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [NRM_W-1:0] nrm_t;
  typedef logic [INV_W-1:0]        inv_t;

  typedef struct packed {
    vel_t first_vel_x;
    vel_t first_vel_y;
    vel_t first_vel_z;
    vel_t second_vel_x;
    vel_t second_vel_y;
    vel_t second_vel_z;
    inv_t first_inv_mass;
    inv_t second_inv_mass;
    logic has_second;
    nrm_t normal_x;
    nrm_t normal_y;
    nrm_t normal_z;
  } in_word_t;

  typedef struct packed {
    vel_t new_first_x;
    vel_t new_first_y;
    vel_t new_first_z;
    vel_t new_second_x;
    vel_t new_second_y;
    vel_t new_second_z;
    logic impulse_applied;
  } out_word_t;

endpackage

@@ hw/rtl/pci_stream_if.sv @@
// ----------------------------------------------------------------------------
// pci_stream_if
// Valid/ready channel that carries one word of type T.
// ----------------------------------------------------------------------------
interface pci_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/pci_div.sv @@
// ----------------------------------------------------------------------------
// pci_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. All stages advance together on adv.
// ----------------------------------------------------------------------------
module pci_div #(
  parameter int DIVIDEND_W = 53,
  parameter int DIVISOR_W  = 33,
  parameter int SIDE_W     = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [SIDE_W-1:0]     side_out
);
  localparam int N = DIVIDEND_W;

  logic                 vld_r  [N];
  logic [DIVISOR_W-1:0] rem_r  [N];
  logic [N-1:0]         num_r  [N];
  logic [N-1:0]         quo_r  [N];
  logic [DIVISOR_W-1:0] dvs_r  [N];
  logic [SIDE_W-1:0]    side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                 vld_i;
    logic [DIVISOR_W-1:0] rem_i;
    logic [DIVISOR_W-1:0] dvs_i;
    logic [N-1:0]         num_i;
    logic [N-1:0]         quo_i;
    logic [SIDE_W-1:0]    side_i;
    logic [DIVISOR_W:0]   trial;
    logic                 ge;

    if (k == 0) begin : g_head
      assign vld_i  = in_valid;
      assign rem_i  = '0;
      assign dvs_i  = divisor;
      assign num_i  = dividend;
      assign quo_i  = '0;
      assign side_i = side_in;
    end else begin : g_body
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign dvs_i  = dvs_r[k-1];
      assign num_i  = num_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Bring down the next dividend bit and try one subtraction.
    assign trial = {rem_i, num_i[N-1]};
    assign ge    = (trial >= {1'b0, dvs_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? DIVISOR_W'(trial - {1'b0, dvs_i}) : trial[DIVISOR_W-1:0];
        num_r[k]  <= {num_i[N-2:0], 1'b0};
        quo_r[k]  <= {quo_i[N-2:0], ge};
        dvs_r[k]  <= dvs_i;
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign quotient  = quo_r[N-1];
  assign side_out  = side_r[N-1];

endmodule

@@ hw/rtl/particle_contact_impulse.sv @@
// ----------------------------------------------------------------------------
// particle_contact_impulse
// Resolves the velocities of one particle contact per word: separating
// velocity, impulse with restitution, and saturated velocity updates.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in_word   sink       valid/ready          one contact (in_word_t)
//  out_word  source     valid/ready          resolved velocities (out_word_t)
//  cfg_*     input      cfg_wr_en only       restitution, unsigned Q1.16
//
// One word enters per cycle when the result side keeps up. The pipeline
// has three front stages (dot product, magnitude, scaling), 53 stages
// of the pipelined divider that forms the impulse, and four back stages
// (inverse-mass product, clamp, per-axis scaling, saturating add into the
// output register). Reset clears all valid bits and sets restitution to zero.
// When a result waits in the output register and out_word.ready is low, the
// whole pipeline holds; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module particle_contact_impulse #(
  parameter int VEL_WIDTH = pci_pkg::PCI_VEL_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  pci_stream_if.sink                  in_word,
  pci_stream_if.source                out_word,
  input  logic                        cfg_wr_en,
  input  logic [pci_pkg::REST_W-1:0]  cfg_wr_data
);
  import pci_pkg::*;

  localparam int PROD_W = VEL_W + NRM_W;      // one axis of the dot product
  localparam int DOT_W  = PROD_W + 2;         // sum of three axes
  localparam int M_W    = DOT_W - 14;         // |s| >> 14
  localparam int SCL_W  = REST_W + 1;         // 1 + restitution
  localparam int D_W    = M_W + SCL_W - 1;    // fits the product bound
  localparam int TOT_W  = INV_W + 1;
  localparam int LO_W   = (D_W + 1) / 2;
  localparam int HI_W   = D_W - LO_W;
  localparam int T_W    = 47;                 // clamped t after >> 16
  localparam int DV_W   = T_W + NRM_W - 14;
  localparam int SUM_W  = 66;

  localparam logic [LO_W+INV_W+HI_W:0] CAP = (LO_W+INV_W+HI_W+1)'(1) << 62;
  localparam logic [T_W-1:0] T_MAX = T_W'(1) << 46;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    (SUM_W'(1) <<< (VEL_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // Per-contact data that rides alongside the arithmetic.
  typedef struct packed {
    vel_t [2:0] vp;
    vel_t [2:0] vq;
    nrm_t [2:0] n;
    inv_t       wp;
    inv_t       wq;
    logic       swap;
    logic       applied;
  } mid_t;

  // Restitution register; write it only while the block is idle (not enforced by the block).
  logic [REST_W-1:0] rest_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= '0;
    end else if (cfg_wr_en) begin
      rest_r <= cfg_wr_data;
    end
  end

  // The whole pipeline moves when the output register can take a word.
  logic      adv;
  logic      out_valid_r;
  out_word_t out_data_r;

  assign adv            = !out_valid_r || out_word.ready;
  assign in_word.ready  = adv;
  assign out_word.valid = out_valid_r;
  assign out_word.data  = out_data_r;

  // --------------------------------------------------------------------------
  // Stage A: choose the primary particle and form the three axis products.
  // The primary is the second particle only when the first is at rest and a
  // second particle exists; a missing second particle contributes zeros.
  // --------------------------------------------------------------------------
  mid_t                     a_mid_nxt, a_mid_r;
  logic [TOT_W-1:0]         a_tot_nxt, a_tot_r;
  logic signed [PROD_W-1:0] a_prod_nxt [3];
  logic signed [PROD_W-1:0] a_prod_r   [3];
  logic                     a_valid_r;

  always_comb begin
    vel_t [2:0] v1;
    vel_t [2:0] v2;
    logic       sec;
    sec   = in_word.data.has_second;
    v1[0] = in_word.data.first_vel_x;
    v1[1] = in_word.data.first_vel_y;
    v1[2] = in_word.data.first_vel_z;
    v2[0] = sec ? in_word.data.second_vel_x : '0;
    v2[1] = sec ? in_word.data.second_vel_y : '0;
    v2[2] = sec ? in_word.data.second_vel_z : '0;
    a_mid_nxt.n[0]    = in_word.data.normal_x;
    a_mid_nxt.n[1]    = in_word.data.normal_y;
    a_mid_nxt.n[2]    = in_word.data.normal_z;
    a_mid_nxt.swap    = sec && (v1[0] == '0) && (v1[1] == '0) && (v1[2] == '0);
    a_mid_nxt.applied = 1'b0;
    if (a_mid_nxt.swap) begin
      a_mid_nxt.vp = v2;
      a_mid_nxt.vq = v1;
      a_mid_nxt.wp = in_word.data.second_inv_mass;
      a_mid_nxt.wq = in_word.data.first_inv_mass;
    end else begin
      a_mid_nxt.vp = v1;
      a_mid_nxt.vq = v2;
      a_mid_nxt.wp = in_word.data.first_inv_mass;
      a_mid_nxt.wq = sec ? in_word.data.second_inv_mass : '0;
    end
    a_tot_nxt = {1'b0, a_mid_nxt.wp} + {1'b0, a_mid_nxt.wq};
    for (int c = 0; c < 3; c++) begin
      a_prod_nxt[c] = PROD_W'($signed(a_mid_nxt.vp[c])) * PROD_W'($signed(a_mid_nxt.n[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_word.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_mid_r <= a_mid_nxt;
      a_tot_r <= a_tot_nxt;
      for (int c = 0; c < 3; c++) begin
        a_prod_r[c] <= a_prod_nxt[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: separating velocity, the impulse decision and |s| >> 14.
  // A zero separating velocity still takes the impulse path.
  // --------------------------------------------------------------------------
  logic signed [DOT_W-1:0] b_dot;
  logic [DOT_W-1:0]        b_mag;
  mid_t                    b_mid_nxt, b_mid_r;
  logic [TOT_W-1:0]        b_tot_r;
  logic [M_W-1:0]          b_m_r;
  logic                    b_valid_r;

  always_comb begin
    b_dot = DOT_W'(a_prod_r[0]) + DOT_W'(a_prod_r[1]) + DOT_W'(a_prod_r[2]);
    b_mag = b_dot[DOT_W-1] ? DOT_W'(-b_dot) : DOT_W'(b_dot);
    b_mid_nxt         = a_mid_r;
    b_mid_nxt.applied = (b_dot <= 0) && (a_tot_r != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mid_r <= b_mid_nxt;
      b_tot_r <= a_tot_r;
      b_m_r   <= b_mag[DOT_W-1:14];
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: scale by (1 + restitution) to form the divider's dividend.
  // --------------------------------------------------------------------------
  mid_t             c_mid_r;
  logic [TOT_W-1:0] c_tot_r;
  logic [D_W-1:0]   c_d_r;
  logic             c_valid_r;
  logic [SCL_W-1:0] c_scale;

  assign c_scale = SCL_W'(1) << 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mid_r <= b_mid_r;
      c_tot_r <= b_tot_r;
      c_d_r   <= D_W'(b_m_r * (c_scale + SCL_W'(rest_r)));
    end
  end

  // --------------------------------------------------------------------------
  // Divider: impulse = dividend / total inverse mass, truncated.
  // --------------------------------------------------------------------------
  logic           q_valid;
  logic [D_W-1:0] q_imp;
  logic [$bits(mid_t)-1:0] q_side;
  mid_t           q_mid;

  pci_div #(
    .DIVIDEND_W (D_W),
    .DIVISOR_W  (TOT_W),
    .SIDE_W     ($bits(mid_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (c_valid_r),
    .dividend  (c_d_r),
    .divisor   (c_tot_r),
    .side_in   (c_mid_r),
    .out_valid (q_valid),
    .quotient  (q_imp),
    .side_out  (q_side)
  );

  assign q_mid = q_side;

  // --------------------------------------------------------------------------
  // Stage E: impulse times each inverse mass, as two partial products apiece.
  // --------------------------------------------------------------------------
  mid_t                    e_mid_r;
  logic [LO_W+INV_W-1:0]   e_plo_r, e_qlo_r;
  logic [HI_W+INV_W-1:0]   e_phi_r, e_qhi_r;
  logic                    e_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
    end else if (adv) begin
      e_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mid_r <= q_mid;
      e_plo_r <= q_imp[LO_W-1:0] * q_mid.wp;
      e_phi_r <= q_imp[D_W-1:LO_W] * q_mid.wp;
      e_qlo_r <= q_imp[LO_W-1:0] * q_mid.wq;
      e_qhi_r <= q_imp[D_W-1:LO_W] * q_mid.wq;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: join the partial products, clamp to 2^62 and drop 16 bits.
  // --------------------------------------------------------------------------
  localparam int FULL_W = LO_W + INV_W + HI_W + 1;

  logic [FULL_W-1:0] f_pfull, f_qfull;
  logic [FULL_W-1:0] f_pclamp, f_qclamp;
  mid_t              f_mid_r;
  logic [T_W-1:0]    f_tp_r, f_tq_r;
  logic              f_valid_r;

  always_comb begin
    f_pfull  = (FULL_W'(e_phi_r) << LO_W) + FULL_W'(e_plo_r);
    f_qfull  = (FULL_W'(e_qhi_r) << LO_W) + FULL_W'(e_qlo_r);
    f_pclamp = (f_pfull > CAP) ? CAP : f_pfull;
    f_qclamp = (f_qfull > CAP) ? CAP : f_qfull;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (adv) begin
      f_valid_r <= e_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_mid_r <= e_mid_r;
      f_tp_r  <= f_pclamp[T_W+15:16];
      f_tq_r  <= f_qclamp[T_W+15:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: per-axis velocity change magnitudes, zero on pass-through.
  // --------------------------------------------------------------------------
  mid_t            g_mid_r;
  logic [DV_W-1:0] g_dvp_r [3];
  logic [DV_W-1:0] g_dvq_r [3];
  logic [DV_W-1:0] g_dvp_nxt [3];
  logic [DV_W-1:0] g_dvq_nxt [3];
  logic            g_valid_r;

  always_comb begin
    logic [NRM_W-1:0]      nmag;
    logic [T_W+NRM_W-1:0]  pp, pq;
    for (int c = 0; c < 3; c++) begin
      nmag = f_mid_r.n[c][NRM_W-1] ? NRM_W'(-f_mid_r.n[c]) : NRM_W'(f_mid_r.n[c]);
      pp   = f_tp_r * nmag;
      pq   = f_tq_r * nmag;
      g_dvp_nxt[c] = f_mid_r.applied ? pp[T_W+NRM_W-1:14] : '0;
      g_dvq_nxt[c] = f_mid_r.applied ? pq[T_W+NRM_W-1:14] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
    end else if (adv) begin
      g_valid_r <= f_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_mid_r <= f_mid_r;
      for (int c = 0; c < 3; c++) begin
        g_dvp_r[c] <= g_dvp_nxt[c];
        g_dvq_r[c] <= g_dvq_nxt[c];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage H: signed add, saturate, and put the particles back in input order.
  // The primary moves along the normal; the other particle moves against it.
  // --------------------------------------------------------------------------
  out_word_t h_out_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] dp, dq, sp, sq;
    vel_t [2:0]              rp, rq;
    for (int c = 0; c < 3; c++) begin
      dp = SUM_W'(g_dvp_r[c]);
      dq = SUM_W'(g_dvq_r[c]);
      sp = SUM_W'($signed(g_mid_r.vp[c])) + (g_mid_r.n[c][NRM_W-1] ? -dp : dp);
      sq = SUM_W'($signed(g_mid_r.vq[c])) + (g_mid_r.n[c][NRM_W-1] ? dq : -dq);
      if (sp > SAT_HI) begin
        sp = SAT_HI;
      end else if (sp < SAT_LO) begin
        sp = SAT_LO;
      end
      if (sq > SAT_HI) begin
        sq = SAT_HI;
      end else if (sq < SAT_LO) begin
        sq = SAT_LO;
      end
      rp[c] = sp[VEL_W-1:0];
      rq[c] = sq[VEL_W-1:0];
    end
    if (g_mid_r.swap) begin
      h_out_nxt.new_first_x  = rq[0];
      h_out_nxt.new_first_y  = rq[1];
      h_out_nxt.new_first_z  = rq[2];
      h_out_nxt.new_second_x = rp[0];
      h_out_nxt.new_second_y = rp[1];
      h_out_nxt.new_second_z = rp[2];
    end else begin
      h_out_nxt.new_first_x  = rp[0];
      h_out_nxt.new_first_y  = rp[1];
      h_out_nxt.new_first_z  = rp[2];
      h_out_nxt.new_second_x = rq[0];
      h_out_nxt.new_second_y = rq[1];
      h_out_nxt.new_second_z = rq[2];
    end
    h_out_nxt.impulse_applied = g_mid_r.applied;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= g_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= h_out_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A word in stage A moves on to stage B whenever the pipeline advances.
  a_front_moves: assert property (@(posedge clk) disable iff (!rst_n)
    adv && a_valid_r |=> b_valid_r)
    else $error("front stage dropped a word");

  // A stall holds the dividend so nothing is recomputed with other data.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(c_d_r) && $stable(c_valid_r))
    else $error("stage C changed during a stall");

  // The clamped impulse product never exceeds 2^46 after the shift.
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid_r |-> (f_tp_r <= T_MAX) && (f_tq_r <= T_MAX))
    else $error("impulse product clamp failed");

  // A pass-through word carries no velocity change into the last stage (x of both particles, z of the primary).
  a_pass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    adv && f_valid_r && !f_mid_r.applied |=>
      (g_dvp_r[0] == '0) && (g_dvq_r[0] == '0) && (g_dvp_r[2] == '0))
    else $error("velocity change on pass-through");

endmodule

@@ tb/sv/tb_particle_contact_impulse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_particle_contact_impulse
// Streams directed and random contacts through the impulse block under
// several restitution settings. A scoreboard class resolves each accepted
// contact in 64-bit integer math and checks every result word field by
// field, in order.
// ----------------------------------------------------------------------------
module tb_particle_contact_impulse;
  import pci_pkg::*;

  // Pipeline depth given for the block, plus some margin.
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  typedef longint vec3_t[3];

  class impulse_scoreboard;
    out_word_t        expected_q[$];
    logic [REST_W-1:0] restitution;
    int               errors;

    function new();
      restitution = '0;
      errors      = 0;
    endfunction

    // Adds (or, for the other particle, subtracts) the impulse along the normal.
    function void push_along_normal(inout vec3_t v, input vec3_t n,
                                    input longint unsigned imp,
                                    input longint unsigned w, input bit neg);
      longint unsigned cap;
      longint unsigned t;
      longint unsigned nm;
      longint          dv;
      bit              minus;
      cap = 64'd1 << 62;
      if (imp != 0 && w > cap / imp) t = cap;
      else t = imp * w;
      t = t >> 16;
      for (int c = 0; c < 3; c++) begin
        nm    = (n[c] < 0) ? longint'(-n[c]) : longint'(n[c]);
        dv    = longint'((t * nm) >> 14);
        minus = (n[c] < 0) != neg;
        v[c]  = minus ? v[c] - dv : v[c] + dv;
      end
    endfunction

    function vel_t clamp_vel(longint v);
      if (v > 64'sd2147483647) return vel_t'(32'h7fffffff);
      if (v < -64'sd2147483648) return vel_t'(32'h80000000);
      return vel_t'(v);
    endfunction

    function out_word_t resolve(in_word_t w);
      vec3_t           v1, v2, n, vp, vq;
      longint unsigned wp, wq, total, m, d, imp;
      longint          s;
      bit              swapped;
      out_word_t       r;
      v1 = '{longint'(w.first_vel_x), longint'(w.first_vel_y), longint'(w.first_vel_z)};
      v2 = '{longint'(w.second_vel_x), longint'(w.second_vel_y), longint'(w.second_vel_z)};
      n  = '{longint'(w.normal_x), longint'(w.normal_y), longint'(w.normal_z)};
      if (!w.has_second) v2 = '{0, 0, 0};
      wp = w.first_inv_mass;
      wq = w.has_second ? longint'(w.second_inv_mass) : 0;
      // A resting first particle hands the primary role to the second one.
      swapped = w.has_second && v1[0] == 0 && v1[1] == 0 && v1[2] == 0;
      if (swapped) begin
        vp = v2; vq = v1;
        wp = w.second_inv_mass;
        wq = w.first_inv_mass;
      end else begin
        vp = v1; vq = v2;
      end
      s     = vp[0] * n[0] + vp[1] * n[1] + vp[2] * n[2];
      total = wp + wq;
      r.impulse_applied = 1'b0;
      if (s <= 0 && total != 0) begin
        r.impulse_applied = 1'b1;
        m   = longint'(-s) >> 14;
        d   = m * (65536 + longint'(restitution));
        imp = d / total;
        push_along_normal(vp, n, imp, wp, 1'b0);
        if (w.has_second) push_along_normal(vq, n, imp, wq, 1'b1);
      end
      if (swapped) begin
        v1 = vq; v2 = vp;
      end else begin
        v1 = vp; v2 = vq;
      end
      r.new_first_x  = clamp_vel(v1[0]);
      r.new_first_y  = clamp_vel(v1[1]);
      r.new_first_z  = clamp_vel(v1[2]);
      r.new_second_x = clamp_vel(v2[0]);
      r.new_second_y = clamp_vel(v2[1]);
      r.new_second_z = clamp_vel(v2[2]);
      return r;
    endfunction

    function void note_contact(in_word_t w);
      expected_q.push_back(resolve(w));
    endfunction

    function void compare_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("new_first_x", e.new_first_x, got.new_first_x);
      compare_field("new_first_y", e.new_first_y, got.new_first_y);
      compare_field("new_first_z", e.new_first_z, got.new_first_z);
      compare_field("new_second_x", e.new_second_x, got.new_second_x);
      compare_field("new_second_y", e.new_second_y, got.new_second_y);
      compare_field("new_second_z", e.new_second_z, got.new_second_z);
      compare_field("impulse_applied", e.impulse_applied, got.impulse_applied);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [REST_W-1:0] cfg_wr_data;

  pci_stream_if #(.T(in_word_t))  in_if ();
  pci_stream_if #(.T(out_word_t)) out_if ();

  particle_contact_impulse u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_word     (in_if),
    .out_word    (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  impulse_scoreboard sb = new();
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic vel_t pick_vel();
    case ($urandom_range(0, 5))
      0: return vel_t'($urandom);
      1: return vel_t'(32'h7fffffff);
      2: return vel_t'(32'h80000000);
      3: return 0;
      default: return vel_t'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
    endcase
  endfunction

  function automatic nrm_t pick_nrm();
    // Mostly components within -1.0 to 1.0 in Q1.14; sometimes any bit pattern.
    if ($urandom_range(0, 4) == 0) return nrm_t'($urandom);
    return nrm_t'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic inv_t pick_inv();
    case ($urandom_range(0, 5))
      0: return inv_t'($urandom);
      1: return 0;
      2: return 32'hffffffff;
      default: return inv_t'($urandom_range(1, 32'h3ffff));
    endcase
  endfunction

  function automatic in_word_t random_contact();
    in_word_t w;
    w.first_vel_x     = pick_vel();
    w.first_vel_y     = pick_vel();
    w.first_vel_z     = pick_vel();
    w.second_vel_x    = pick_vel();
    w.second_vel_y    = pick_vel();
    w.second_vel_z    = pick_vel();
    w.first_inv_mass  = pick_inv();
    w.second_inv_mass = pick_inv();
    w.has_second      = 1'($urandom_range(0, 1));
    w.normal_x        = pick_nrm();
    w.normal_y        = pick_nrm();
    w.normal_z        = pick_nrm();
    // A resting first particle exercises the role swap.
    if ($urandom_range(0, 7) == 0) begin
      w.first_vel_x = 0;
      w.first_vel_y = 0;
      w.first_vel_z = 0;
    end
    return w;
  endfunction

  // Presents one word and holds it until the block takes it.
  task automatic send_contact(in_word_t w);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
    sb.note_contact(w);
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Lets every expected word come back, then lets the pipeline run dry.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_restitution(logic [REST_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.restitution = value;
    @(posedge clk);
  endtask

  task automatic directed_contacts();
    in_word_t w;
    // Head-on contact with the fastest possible approach and the largest
    // normal component: deep saturation of both particles.
    w = '{first_vel_x: 32'h80000000, first_vel_y: 32'h7fffffff,
          first_vel_z: 32'h80000000, second_vel_x: 32'h7fffffff,
          second_vel_y: 32'h80000000, second_vel_z: 32'h7fffffff,
          first_inv_mass: 32'hffffffff, second_inv_mass: 32'hffffffff,
          has_second: 1'b1, normal_x: 16'h7fff, normal_y: 16'h8000,
          normal_z: 16'h7fff};
    send_contact(w);
    w.normal_x = 16'h8000; w.normal_y = 16'h7fff; w.normal_z = 16'h8000;
    send_contact(w);
    // Small inverse masses so the clamp on the mass product is not hit.
    w.first_inv_mass = 32'h1; w.second_inv_mass = 32'h1;
    send_contact(w);
    // Both inverse masses zero: the velocities pass through.
    w.first_inv_mass = 0; w.second_inv_mass = 0;
    send_contact(w);
    // Separating contact (positive dot product) passes through.
    w = '{first_vel_x: 32'h00010000, first_vel_y: 0, first_vel_z: 0,
          second_vel_x: 32'hffff0000, second_vel_y: 0, second_vel_z: 0,
          first_inv_mass: 32'h00010000, second_inv_mass: 32'h00010000,
          has_second: 1'b1, normal_x: 16'h4000, normal_y: 0, normal_z: 0};
    send_contact(w);
    // Same contact approaching: a normal bounce.
    w.normal_x = 16'hc000;
    send_contact(w);
    // Fixed world: no second particle, its fields must read as zero.
    w.has_second = 1'b0;
    send_contact(w);
    // No second particle and a first particle at rest: no swap.
    w.first_vel_x = 0;
    send_contact(w);
    // First particle at rest with a second one: roles swap.
    w.has_second = 1'b1;
    w.second_vel_x = 32'h00020000;
    w.normal_x = 16'hc000;
    send_contact(w);
    w.normal_x = 16'h4000;
    send_contact(w);
    // Zero separating velocity through a zero normal: impulse path, no change.
    w.first_vel_x = 32'h00030000; w.normal_x = 0;
    send_contact(w);
    // Perpendicular motion also gives a zero dot product.
    w.normal_y = 16'h4000;
    send_contact(w);
    // Only the other particle has mass; only the primary has mass.
    w.normal_x = 16'hc000; w.normal_y = 0;
    w.first_inv_mass = 0;
    send_contact(w);
    w.first_inv_mass = 32'h00010000; w.second_inv_mass = 0;
    send_contact(w);
    // Non-unit normal, all components negative.
    w.normal_x = 16'h8001; w.normal_y = 16'h9000; w.normal_z = 16'hffff;
    w.first_vel_y = 32'h12345678; w.first_vel_z = 32'h00abcdef;
    send_contact(w);
  endtask

  // Result side: checks accepted words and stalls at random.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_result(out_if.data);
    end
  end

  // Watchdog.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** particle_contact_impulse: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus: directed contacts, then random phases under several
  // restitution settings, with one pause mid-phase until the pipe drains.
  initial begin
    logic [REST_W-1:0] settings[5];
    settings = '{17'd65536, 17'd131071, 17'd0, 17'd32768, 17'($urandom)};
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset restitution is zero; check it before any write.
    directed_contacts();
    drain();
    write_restitution(17'd131071);
    directed_contacts();
    drain();

    foreach (settings[p]) begin
      write_restitution(settings[p]);
      for (int i = 0; i < 150; i++) begin
        send_contact(random_contact());
        if (p == 1 && i == 75) drain();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("** particle_contact_impulse: PASSED **");
    end else begin
      $display("** particle_contact_impulse: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/pci_pkg.sv
hw/rtl/pci_stream_if.sv
hw/rtl/pci_div.sv
hw/rtl/particle_contact_impulse.sv
tb/sv/tb_particle_contact_impulse.sv
